FILE: design/ott_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ott_pkg
// Types, codes and helpers of the ordered timer table.
// ----------------------------------------------------------------------------
package ott_pkg;

  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_CANCEL  = 3'd1;
  localparam logic [2:0] ACT_REFRESH = 3'd2;
  localparam logic [2:0] ACT_RESET   = 3'd3;
  localparam logic [2:0] ACT_COLLECT = 3'd4;
  localparam logic [2:0] ACT_QUERY   = 3'd5;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_REFUSED = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_EXPIRED = 3'd3;
  localparam logic [2:0] STAT_NONE    = 3'd4;

  localparam logic [47:0] MASK48           = 48'hFFFF_FFFF_FFFF;
  localparam int          MAX_RES          = 32;
  localparam logic [31:0] ROLLBACK_DEFAULT = 32'd3600000;

  typedef struct packed {
    logic        recurring;
    logic [31:0] period;
    logic [47:0] deadline;
  } entry_t;

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? MASK48 : s[47:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/ordered_timer_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_timer_table_top
// Deadline-ordered timer table; slot fields live in a one-port-read RAM.
// ----------------------------------------------------------------------------
// Scans read 1 slot/cycle. Collect first scans for due entries, then runs one
//   further scan per expired entry to pick the earliest due one.
// One request at a time; the next is taken while the last result waits.
// Reset (sync, active low) clears active bits, wake flag and last check time.
module ordered_timer_table_top #(
  parameter int SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // timer_id[4:0] period_ms[36:5] recurring[37] now_based[38] now_ms[86:39]
  input  wire logic [87:0] in_tdata,
  // action[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_id[4:0] wait_ms[52:5] no_timer[53] wake[54]
  output logic [55:0]      out_tdata,
  // status[2:0]
  output logic [2:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);
  import ott_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_MOD  = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_DONE = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t         state_r;
  logic [2:0]     act_r;
  logic [31:0]    per_r;
  logic           rec_r;
  logic           fn_r;
  logic [47:0]    now_r;
  logic [IW-1:0]  slot_r;
  logic [31:0]    win_r;
  logic [47:0]    last_chk_r;
  logic           wake_pend_r;
  logic [SLOTS-1:0] active_r;
  logic [SLOTS-1:0] due_r;
  logic           rollover_r;
  logic [CW-1:0]  due_cnt_r;
  logic [6:0]     emit_n_r;
  logic           scan_due_r;
  logic           scan_act_r;
  logic [CW-1:0]  cnt_r;
  logic           rd_vld_r;
  logic [IW-1:0]  rd_idx_r;
  logic           best_vld_r;
  logic [IW-1:0]  best_idx_r;
  logic [47:0]    best_dl_r;
  logic [31:0]    best_per_r;
  logic           best_rec_r;
  logic [2:0]     res_status_r;
  logic [4:0]     res_id_r;
  logic [47:0]    res_wait_r;
  logic           res_nt_r;
  logic           res_wake_r;
  logic           res_last_r;
  logic           out_valid_r;
  logic [2:0]     out_status_r;
  logic [4:0]     out_id_r;
  logic [47:0]    out_wait_r;
  logic           out_nt_r;
  logic           out_wake_r;
  logic           out_last_r;

  // request fields
  logic [4:0]     in_id;
  logic [31:0]    in_per;
  logic [47:0]    in_now;
  logic           in_valid_id;
  logic [IW+4:0]  in_slot_ext;
  logic [IW-1:0]  in_slot;

  assign in_id       = in_tdata[4:0];
  assign in_per      = in_tdata[36:5];
  assign in_now      = in_tdata[86:39];
  assign in_valid_id = (32'(in_id) < 32'(SLOTS));
  assign in_slot_ext = {{IW{1'b0}}, in_id};
  assign in_slot     = in_slot_ext[IW-1:0];

  function automatic logic [4:0] id5(input logic [IW-1:0] x);
    logic [IW+4:0] t;
    t = {5'b0, x};
    return t[4:0];
  endfunction

  // memory ports
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  entry_t        rd_e;

  ott_ram #(
    .DEPTH (SLOTS),
    .AW    (IW),
    .DW    ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_e)
  );

  // lowest free slot
  logic          free_vld;
  logic [IW-1:0] free_idx;

  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_vld = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  logic        rs_same;
  logic [47:0] rs_start;
  logic [47:0] rd_per48;
  logic        scan_end;
  logic        scan_hit;
  logic [6:0]  lim;
  logic        emit_last;
  logic        emit_ld;

  assign rd_per48 = {16'b0, rd_e.period};
  assign rs_same  = (per_r == rd_e.period) && !fn_r;
  assign rs_start = fn_r ? now_r :
                    ((rd_e.deadline >= rd_per48) ? rd_e.deadline - rd_per48 : '0);
  assign scan_end = (cnt_r == CW'(SLOTS)) && !rd_vld_r;
  assign scan_hit = (scan_act_r ? active_r[rd_idx_r] : due_r[rd_idx_r]) &&
                    (!best_vld_r || (rd_e.deadline < best_dl_r));
  assign lim       = (32'(due_cnt_r) >= 32'(MAX_RES)) ? 7'(MAX_RES) : 7'(due_cnt_r);
  assign emit_last = ((emit_n_r + 7'd1) == lim);
  assign emit_ld   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = '{recurring: rd_e.recurring, period: rd_e.period,
                  deadline: sat_add(now_r, rd_e.period)};
    mem_re    = 1'b0;
    mem_raddr = slot_r;
    case (state_r)
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_SCAN: begin
        mem_re    = (cnt_r != CW'(SLOTS));
        mem_raddr = cnt_r[IW-1:0];
      end
      ST_MOD: begin
        case (act_r)
          ACT_ADD: begin
            mem_we    = free_vld;
            mem_waddr = free_idx;
            mem_wdata = '{recurring: rec_r, period: per_r,
                          deadline: sat_add(now_r, per_r)};
          end
          ACT_REFRESH: begin
            mem_we = 1'b1;
          end
          ACT_RESET: begin
            mem_we    = !rs_same && active_r[slot_r];
            mem_wdata = '{recurring: rd_e.recurring, period: per_r,
                          deadline: sat_add(rs_start, per_r)};
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      ST_DONE: begin
        // re-arm a recurring expired timer
        mem_we    = (act_r == ACT_COLLECT) && !scan_due_r && best_rec_r;
        mem_waddr = best_idx_r;
        mem_wdata = '{recurring: 1'b1, period: best_per_r,
                      deadline: sat_add(now_r, best_per_r)};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= ROLLBACK_DEFAULT;
      last_chk_r  <= '0;
      wake_pend_r <= 1'b0;
      active_r    <= '0;
      due_r       <= '0;
      due_cnt_r   <= '0;
      emit_n_r    <= '0;
      scan_due_r  <= 1'b0;
      scan_act_r  <= 1'b0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end

      if (emit_ld) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res_status_r;
        out_id_r     <= res_id_r;
        out_wait_r   <= res_wait_r;
        out_nt_r     <= res_nt_r;
        out_wake_r   <= res_wake_r;
        out_last_r   <= res_last_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            act_r        <= in_tuser;
            per_r        <= in_per;
            rec_r        <= in_tdata[37];
            fn_r         <= in_tdata[38];
            now_r        <= in_now;
            slot_r       <= in_slot;
            res_status_r <= STAT_OK;
            res_id_r     <= '0;
            res_wait_r   <= '0;
            res_nt_r     <= 1'b0;
            res_wake_r   <= 1'b0;
            res_last_r   <= 1'b1;
            cnt_r        <= '0;
            rd_vld_r     <= 1'b0;
            best_vld_r   <= 1'b0;
            case (in_tuser)
              ACT_ADD: begin
                state_r <= ST_MOD;
              end
              ACT_CANCEL: begin
                if (in_valid_id && active_r[in_slot]) begin
                  active_r[in_slot] <= 1'b0;
                end else begin
                  res_status_r <= STAT_REFUSED;
                end
                state_r <= ST_EMIT;
              end
              ACT_REFRESH: begin
                if (in_valid_id && active_r[in_slot]) begin
                  state_r <= ST_RD;
                end else begin
                  res_status_r <= STAT_REFUSED;
                  state_r      <= ST_EMIT;
                end
              end
              ACT_RESET: begin
                if (in_valid_id) begin
                  state_r <= ST_RD;
                end else begin
                  res_status_r <= STAT_REFUSED;
                  state_r      <= ST_EMIT;
                end
              end
              ACT_COLLECT: begin
                rollover_r <= (last_chk_r >= {16'b0, win_r}) &&
                              (in_now < last_chk_r - {16'b0, win_r});
                last_chk_r <= in_now;
                due_r      <= '0;
                due_cnt_r  <= '0;
                emit_n_r   <= '0;
                scan_due_r <= 1'b1;
                state_r    <= ST_SCAN;
              end
              ACT_QUERY: begin
                wake_pend_r <= 1'b0;
                scan_due_r  <= 1'b0;
                scan_act_r  <= 1'b1;
                state_r     <= ST_SCAN;
              end
              default: begin
                res_status_r <= STAT_REFUSED;
                state_r      <= ST_EMIT;
              end
            endcase
          end
        end
        ST_RD: begin
          state_r <= ST_MOD;
        end
        ST_MOD: begin
          state_r    <= ST_EMIT;
          scan_due_r <= 1'b0;
          scan_act_r <= 1'b1;
          case (act_r)
            ACT_ADD: begin
              if (!free_vld) begin
                res_status_r <= STAT_FULL;
              end else begin
                active_r[free_idx] <= 1'b1;
                slot_r             <= free_idx;
                res_id_r           <= id5(free_idx);
                if (!wake_pend_r) begin
                  state_r <= ST_SCAN;
                end
              end
            end
            ACT_RESET: begin
              if (!rs_same) begin
                if (!active_r[slot_r]) begin
                  res_status_r <= STAT_REFUSED;
                end else if (!wake_pend_r) begin
                  state_r <= ST_SCAN;
                end
              end
            end
            default: begin
              state_r <= ST_EMIT;
            end
          endcase
        end
        ST_SCAN: begin
          if (cnt_r != CW'(SLOTS)) begin
            cnt_r <= cnt_r + CW'(1);
          end
          rd_idx_r <= cnt_r[IW-1:0];
          rd_vld_r <= (cnt_r != CW'(SLOTS));
          if (rd_vld_r) begin
            if (scan_due_r) begin
              if (active_r[rd_idx_r] && (rollover_r || (rd_e.deadline <= now_r))) begin
                due_r[rd_idx_r] <= 1'b1;
                due_cnt_r       <= due_cnt_r + CW'(1);
              end
            end else if (scan_hit) begin
              // strict compare keeps the lower slot on equal deadlines
              best_vld_r <= 1'b1;
              best_idx_r <= rd_idx_r;
              best_dl_r  <= rd_e.deadline;
              best_per_r <= rd_e.period;
              best_rec_r <= rd_e.recurring;
            end
          end
          if (scan_end) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          state_r <= ST_EMIT;
          case (act_r)
            ACT_COLLECT: begin
              if (scan_due_r) begin
                if (due_cnt_r == '0) begin
                  res_status_r <= STAT_NONE;
                end else begin
                  scan_due_r <= 1'b0;
                  scan_act_r <= 1'b0;
                  cnt_r      <= '0;
                  rd_vld_r   <= 1'b0;
                  best_vld_r <= 1'b0;
                  state_r    <= ST_SCAN;
                end
              end else begin
                res_status_r       <= STAT_EXPIRED;
                res_id_r           <= id5(best_idx_r);
                res_last_r         <= emit_last;
                due_r[best_idx_r]  <= 1'b0;
                emit_n_r           <= emit_n_r + 7'd1;
                if (!best_rec_r) begin
                  active_r[best_idx_r] <= 1'b0;
                end
              end
            end
            ACT_QUERY: begin
              if (!best_vld_r) begin
                res_wait_r <= MASK48;
                res_nt_r   <= 1'b1;
              end else begin
                res_wait_r <= (now_r >= best_dl_r) ? '0 : best_dl_r - now_r;
              end
            end
            default: begin
              // add or reset: front check
              if (best_idx_r == slot_r) begin
                wake_pend_r <= 1'b1;
                res_wake_r  <= 1'b1;
              end
            end
          endcase
        end
        ST_EMIT: begin
          if (emit_ld) begin
            if ((act_r == ACT_COLLECT) && !res_last_r) begin
              cnt_r      <= '0;
              rd_vld_r   <= 1'b0;
              best_vld_r <= 1'b0;
              state_r    <= ST_SCAN;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_wake_r, out_nt_r, out_wait_r, out_id_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_we)
    else $error("slot RAM written during a scan");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r == ACT_COLLECT && state_r != ST_IDLE) |-> (emit_n_r <= 7'(MAX_RES)))
    else $error("collect emitted too many entries");

  a_emit_vs_due: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && act_r == ACT_COLLECT && !scan_due_r) |-> best_vld_r)
    else $error("collect scan found no due entry");

endmodule
`default_nettype wire

FILE: design/ott_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ott_ram
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ott_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 81
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
